/* rtl/sdau_pkg.sv */
// ----------------------------------------------------------------------------
// sdau_pkg
// Shared types, constants and helpers for the signed decimal ascii unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sdau_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] BCD_FIVE  = 4'd5;
    localparam logic [3:0] BCD_THREE = 4'd3;

    // decimal digits needed for an unsigned magnitude of bits bits
    function automatic int digit_count(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } sdau_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } sdau_state_t;

endpackage

`default_nettype wire

/* rtl/sdau_bcd_cell.sv */
// ----------------------------------------------------------------------------
// sdau_bcd_cell
// One decimal digit of the conversion chain: add-3 and shift during
// conversion, digit hand-over toward the top during emission.
// ----------------------------------------------------------------------------
`default_nettype none

module sdau_bcd_cell (
    input  wire                     aclk,
    input  wire sdau_pkg::sdau_ctrl_t ctrl,
    input  wire                     carry_in,
    input  wire  [3:0]              digit_in,
    output logic                    carry_out,
    output logic [3:0]              digit_out
);
    import sdau_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    assign adj       = (digit_reg >= BCD_FIVE) ? (digit_reg + BCD_THREE) : digit_reg;
    assign carry_out = adj[3];
    assign digit_out = digit_reg;

    always_comb begin
        priority if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.conv) begin
            digit_next = {adj[2:0], carry_in};
        end else if (ctrl.shift) begin
            digit_next = digit_in;
        end else begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

/* rtl/signed_int_to_decimal_ascii_unit.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Signed integer to decimal ascii text, one character per output beat.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                     | tlast
//  s_       | in        | value (VALUE_BITS, signed)| -
//  m_       | out       | ascii_char (8)            | last_char
//
//  accept, then a shift-and-adjust pass through the digit cell chain for
//  each value bit, then a minus sign for a negative value, then the digit
//  cells from the top, with leading zero cells dropped.
//  output stalls hold the emission; s_tready is high only between values.
//  synchronous active-low reset clears the control and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = sdau_pkg::DEFAULT_VALUE_BITS,
    parameter int TDATA_W    = ((VALUE_BITS + 7) / 8) * 8
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire  [TDATA_W-1:0]   s_tdata,   // value
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [7:0]           m_tdata,   // ascii_char
    output logic                 m_tlast    // last_char
);
    import sdau_pkg::*;

    localparam int NUM_DIGITS = digit_count(VALUE_BITS);
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int BIT_W      = $clog2(VALUE_BITS + 1);

    sdau_state_t            state_reg, state_next;
    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]       dig_cnt_reg, dig_cnt_next;
    logic                   started_reg, started_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [7:0]             m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic [VALUE_BITS-1:0]  raw;
    logic                   accept;
    logic                   out_free;
    logic [3:0]             top_digit;
    sdau_ctrl_t             ctrl;

    logic [NUM_DIGITS:0]    carry;
    logic [3:0]             digits [NUM_DIGITS];

    assign raw      = s_tdata[VALUE_BITS-1:0];
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign top_digit = digits[NUM_DIGITS-1];

    assign carry[0] = mag_reg[VALUE_BITS-1];

    genvar g;
    generate
        for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
            logic [3:0] digit_in;
            if (g == 0) begin : g_first
                assign digit_in = 4'd0;
            end else begin : g_rest
                assign digit_in = digits[g-1];
            end
            sdau_bcd_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .carry_in  (carry[g]),
                .digit_in  (digit_in),
                .carry_out (carry[g+1]),
                .digit_out (digits[g])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        bit_cnt_next  = bit_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        started_next  = started_reg;
        m_tvalid_next = out_free ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        ctrl          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next     = raw[VALUE_BITS-1];
                    mag_next     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
                    bit_cnt_next = BIT_W'(VALUE_BITS);
                    dig_cnt_next = CNT_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    ctrl.clear   = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                ctrl.conv    = 1'b1;
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BIT_W'(1)) begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = CHAR_MINUS;
                    m_tlast_next  = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ctrl.shift   = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (started_reg || top_digit != 4'd0 || dig_cnt_reg == CNT_W'(1)) begin
                        started_next  = 1'b1;
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = CHAR_ZERO + {4'd0, top_digit};
                        m_tlast_next  = (dig_cnt_reg == CNT_W'(1));
                    end
                    if (dig_cnt_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        started_reg <= started_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

/* rtl/sdau_checker.sv */
// ----------------------------------------------------------------------------
// sdau_checker
// Port-level checks for the signed decimal ascii unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sdau_checker #(
    parameter int VALUE_BITS = sdau_pkg::DEFAULT_VALUE_BITS,
    parameter int TDATA_W    = ((VALUE_BITS + 7) / 8) * 8
) (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_tvalid,
    input wire                s_tready,
    input wire  [TDATA_W-1:0] s_tdata,   // value
    input wire                m_tvalid,
    input wire                m_tready,
    input wire  [7:0]         m_tdata,   // ascii_char
    input wire                m_tlast    // last_char
);
    import sdau_pkg::*;

    logic s_beat;
    assign s_beat = s_tvalid && s_tready && (s_tdata == s_tdata);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == CHAR_MINUS) || (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE))
        else $error("output character outside sign and digits");

    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == CHAR_MINUS |-> !m_tlast)
        else $error("minus sign marked as last character");

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> !s_tready)
        else $error("input ready right after an accepted beat");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii_unit sdau_checker #(
    .VALUE_BITS (VALUE_BITS),
    .TDATA_W    (TDATA_W)
) u_sdau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/decimal_text_checker.sv */
// ----------------------------------------------------------------------------
// decimal_text_checker
// Watches both stream channels of the signed decimal ascii unit. Every value
// accepted on the input is turned into its expected decimal text, and every
// output beat is compared with the oldest expected character and last flag.
// ----------------------------------------------------------------------------
module decimal_text_checker #(
    parameter int VW = sdau_pkg::DEFAULT_VALUE_BITS
) (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           s_tvalid,
    input  wire           s_tready,
    input  wire  [VW-1:0] s_tdata,    // value
    input  wire           m_tvalid,
    input  wire           m_tready,
    input  wire  [7:0]    m_tdata,    // ascii_char
    input  wire           m_tlast,    // last_char
    output int            fail_count,
    output int            pending,
    output int            beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    text_char_t char_q[$];

    initial begin
        fail_count    = 0;
        pending       = 0;
        beats_checked = 0;
    end

    task automatic report(input string what);
        $display("%0t ns  error on output beat %0d: %s", $realtime, beats_checked, what);
        fail_count++;
    endtask

    // decimal text of one signed value, sign first, digits most significant first
    function automatic void push_decimal_text(input logic [VW-1:0] value);
        logic [VW-1:0] mag;
        logic [7:0]    digs[$];
        text_char_t    c;
        mag = value[VW-1] ? (~value + 1'b1) : value;
        do begin
            digs.push_front(sdau_pkg::CHAR_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (value[VW-1]) begin
            c.ch   = sdau_pkg::CHAR_MINUS;
            c.last = 1'b0;
            char_q.push_back(c);
        end
        foreach (digs[i]) begin
            c.ch   = digs[i];
            c.last = (i == digs.size() - 1);
            char_q.push_back(c);
        end
    endfunction

    always @(posedge aclk) begin : watch
        text_char_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                push_decimal_text(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (char_q.size() == 0) begin
                    report($sformatf("unexpected beat, char %h last %b", m_tdata, m_tlast));
                end else begin
                    want = char_q.pop_front();
                    if (m_tdata !== want.ch) begin
                        report($sformatf("char got %h want %h", m_tdata, want.ch));
                    end
                    if (m_tlast !== want.last) begin
                        report($sformatf("last got %b want %b", m_tlast, want.last));
                    end
                end
                beats_checked <= beats_checked + 1;
            end
        end
        pending <= char_q.size();
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for signed_int_to_decimal_ascii_unit. Sends corner
// values, then random values spread over every digit length and sign, with
// bursty input, a patterned output stall, a long output hold-off and a full
// drain mid-run. Checking is done by decimal_text_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW           = sdau_pkg::DEFAULT_VALUE_BITS;
    localparam int RANDOM_ITEMS = 210;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 60;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int N_CORNERS    = 20;

    localparam logic [VW-1:0] CORNERS [N_CORNERS] = '{
        32'd0, 32'd1, 32'(-1), 32'd9, 32'd10, 32'(-9), 32'(-10), 32'd99, 32'd100,
        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
        32'(-1000000000), 32'd123456789, 32'(-123456789), 32'h5555_5555,
        32'hAAAA_AAAA, 32'd2000000000
    };

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [VW-1:0] s_tdata;     // value
    logic          m_tvalid;
    logic          m_tready;
    logic [7:0]    m_tdata;     // ascii_char
    logic          m_tlast;     // last_char

    int fail_count;
    int pending;
    int beats_checked;
    int values_sent;
    int negatives_sent;
    int burst_left;
    bit hold_go;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    signed_int_to_decimal_ascii_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    decimal_text_checker #(.VW(VW)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    task automatic offer(input logic [VW-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= v;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        values_sent++;
        if (v[VW-1]) negatives_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [VW-1:0] pick_value();
        longint lo;
        longint hi;
        longint v;
        int     digits;
        int     mode;
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            return $urandom;
        end else if (mode == 2) begin
            // powers of ten and their neighbors, plus the range ends
            if ($urandom_range(0, 3) == 0) begin
                return CORNERS[$urandom_range(9, 11)];
            end
            v = 1;
            repeat ($urandom_range(0, 9)) v = v * 10;
            v = v + $urandom_range(0, 2) - 1;
        end else begin
            digits = $urandom_range(1, 10);
            lo = 1;
            repeat (digits - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (digits == 1) lo = 0;
            if (hi > 64'sd2147483647) hi = 64'sd2147483647;
            v = lo + longint'($urandom) % (hi - lo + 1);
        end
        if ($urandom_range(0, 1) == 1) v = -v;
        return VW'(v);
    endfunction

    // output side: rotating stall pattern, plus one long hold-off on request
    initial begin : sink
        int tick;
        int held;
        bit hold_done;
        m_tready  = 1'b0;
        tick      = 0;
        hold_done = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_go && !hold_done) begin
                hold_done = 1;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
            end
            case ((tick / 128) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                2: m_tready <= ($urandom_range(0, 9) < 3);
                default: m_tready <= ((tick % 7) < 3);
            endcase
        end
    end

    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge aclk);
        $display("timeout after %0d cycles, %0d characters still expected", cycles, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int n;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        hold_go        = 0;
        values_sent    = 0;
        negatives_sent = 0;
        burst_left     = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (CORNERS[i]) offer(CORNERS[i]);
        wait_drained();

        // long hold-off while the sender keeps offering
        hold_go <= 1'b1;
        for (n = 0; n < RANDOM_ITEMS / 3; n++) offer(pick_value());
        wait_drained();
        for (n = RANDOM_ITEMS / 3; n < RANDOM_ITEMS; n++) offer(pick_value());
        wait_drained();
        repeat (SETTLE) @(posedge aclk);

        $display("run covered %0d values, %0d negative, with range ends, zero and every length",
                 values_sent, negatives_sent);
        $display("%0d characters checked under input gaps, output stalls and a long hold-off",
                 beats_checked);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/sdau_pkg.sv
rtl/sdau_bcd_cell.sv
rtl/signed_int_to_decimal_ascii_unit.sv
rtl/sdau_checker.sv
tb/decimal_text_checker.sv
tb/tb_top.sv
